// File: hdl/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Types and constants shared by the round-robin schedule simulator.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned MAX_PROCS = 64;
  localparam int unsigned ID_W      = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W     = ID_W + 1;
  localparam int unsigned TIME_W    = 23;
  localparam int unsigned IN_W      = 16;
  localparam logic [IN_W-1:0] QUANTUM_RESET = 16'd4;

  typedef struct packed {
    logic [IN_W-1:0] arrival_time;
    logic [IN_W-1:0] burst_time;
    logic            last_process;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              last_result;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_ADM_RD,
    S_ADM_CK,
    S_MIN_RD,
    S_MIN_CK,
    S_POP,
    S_POP2,
    S_REM,
    S_RUN,
    S_PUSH,
    S_OUT_RD,
    S_OUT_CK,
    S_OUT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    ADM_FIRST,
    ADM_MIN,
    ADM_DONE,
    ADM_PRE
  } adm_kind_t;

endpackage

// File: hdl/round_robin_schedule_sim.sv
`timescale 1ns / 1ps
// A non-final transaction is written to the memories as it is taken. The final one, or
// the one that fills the memories, starts the simulation: each turn runs S_TOP, S_POP,
// S_POP2, S_REM, S_RUN (and S_PUSH when the process is preempted) plus one arrival scan
// of every stored process, one more when the ready queue runs empty and two more when
// time skips to the next arrival, all set by the single read port of the arrival memory.
// Results await out_ready. Reset clears control state, quantum 4; memories hold no reset.
// ----------------------------------------------------------------------------
// round_robin_schedule_sim
// Round-robin CPU scheduling simulator over memories for per-process state.
// ----------------------------------------------------------------------------
module round_robin_schedule_sim
  import rrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IN_W-1:0] cfg_data
);

  logic [IN_W-1:0]   arr_mem   [MAX_PROCS];
  logic [IN_W-1:0]   burst_mem [MAX_PROCS];
  logic [IN_W-1:0]   rem_mem   [MAX_PROCS];
  logic [TIME_W-1:0] start_mem [MAX_PROCS];
  logic [TIME_W-1:0] fin_mem   [MAX_PROCS];
  logic [ID_W-1:0]   ring_mem  [MAX_PROCS];

  logic [IN_W-1:0]   arr_rd_r, burst_rd_r, rem_rd_r;
  logic [TIME_W-1:0] start_rd_r, fin_rd_r;
  logic [ID_W-1:0]   ring_rd_r;

  state_t            state_r, state_nxt;
  adm_kind_t         kind_r, kind_nxt;
  logic [IN_W-1:0]   q_r;
  logic [CNT_W-1:0]  pcount_r, pcount_nxt;
  logic [CNT_W-1:0]  fin_cnt_r, fin_cnt_nxt;
  logic [CNT_W-1:0]  ring_cnt_r, ring_cnt_nxt;
  logic [ID_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [ID_W-1:0]   j_r, j_nxt, id_r, id_nxt;
  logic [TIME_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, next_r, next_nxt;
  logic              prev_neg_r, prev_neg_nxt, found_r, found_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt, started_r, started_nxt;
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              load_we, rem_we, start_we, fin_we, ring_we;
  logic [ID_W-1:0]   rem_wa, ring_wd;
  logic [IN_W-1:0]   rem_wd;
  logic [TIME_W-1:0] fin_wd;

  logic [IN_W-1:0]   q_eff;
  logic [TIME_W-1:0] a_ext, tat, wt;
  logic              last_j, hit, cand;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign q_eff  = (q_r == '0) ? {{(IN_W-1){1'b0}}, 1'b1} : q_r;
  assign a_ext  = {{(TIME_W-IN_W){1'b0}}, arr_rd_r};
  assign last_j = ({1'b0, j_r} == pcount_r - {{(CNT_W-1){1'b0}}, 1'b1});
  assign hit    = !done_r[j_r] && (prev_neg_r || a_ext > prev_r) && (a_ext <= cur_r);
  assign cand   = !done_r[j_r] && (a_ext > cur_r) && (!found_r || a_ext < next_r);
  assign tat    = fin_rd_r - a_ext;
  assign wt     = tat - {{(TIME_W-IN_W){1'b0}}, burst_rd_r};

  always_ff @(posedge clk) begin
    if (load_we) begin
      arr_mem[pcount_r[ID_W-1:0]]   <= in_data.arrival_time;
      burst_mem[pcount_r[ID_W-1:0]] <= in_data.burst_time;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (start_we) begin
      start_mem[id_r] <= cur_r;
    end
    if (fin_we) begin
      fin_mem[id_r] <= fin_wd;
    end
    if (ring_we) begin
      ring_mem[tail_r] <= ring_wd;
    end
    arr_rd_r   <= arr_mem[j_r];
    burst_rd_r <= burst_mem[j_r];
    start_rd_r <= start_mem[j_r];
    fin_rd_r   <= fin_mem[j_r];
    rem_rd_r   <= rem_mem[id_r];
    ring_rd_r  <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= ADM_FIRST;
      q_r         <= QUANTUM_RESET;
      pcount_r    <= '0;
      fin_cnt_r   <= '0;
      ring_cnt_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cur_r       <= '0;
      prev_neg_r  <= 1'b1;
      done_r      <= '0;
      started_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      pcount_r    <= pcount_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      ring_cnt_r  <= ring_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_r       <= cur_nxt;
      prev_neg_r  <= prev_neg_nxt;
      done_r      <= done_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        q_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    id_r    <= id_nxt;
    prev_r  <= prev_nxt;
    next_r  <= next_nxt;
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pcount_nxt    = pcount_r;
    fin_cnt_nxt   = fin_cnt_r;
    ring_cnt_nxt  = ring_cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    j_nxt         = j_r;
    id_nxt        = id_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_neg_nxt  = prev_neg_r;
    next_nxt      = next_r;
    found_nxt     = found_r;
    done_nxt      = done_r;
    started_nxt   = started_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    load_we       = 1'b0;
    rem_we        = 1'b0;
    rem_wa        = id_r;
    rem_wd        = rem_rd_r - q_eff;
    start_we      = 1'b0;
    fin_we        = 1'b0;
    fin_wd        = cur_r + {{(TIME_W-IN_W){1'b0}}, rem_rd_r};
    ring_we       = 1'b0;
    ring_wd       = j_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          load_we    = 1'b1;
          rem_we     = 1'b1;
          rem_wa     = pcount_r[ID_W-1:0];
          rem_wd     = in_data.burst_time;
          pcount_nxt = pcount_r + {{(CNT_W-1){1'b0}}, 1'b1};
          if (in_data.last_process || pcount_r == CNT_W'(MAX_PROCS - 1)) begin
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        j_nxt = '0;
        if (fin_cnt_r == pcount_r) begin
          state_nxt = S_OUT_RD;
        end else if (ring_cnt_r == '0) begin
          kind_nxt  = ADM_FIRST;
          state_nxt = S_ADM_RD;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_ADM_RD: begin
        state_nxt = S_ADM_CK;
      end
      S_ADM_CK: begin
        if (hit) begin
          ring_we      = 1'b1;
          tail_nxt     = tail_r + {{(ID_W-1){1'b0}}, 1'b1};
          ring_cnt_nxt = ring_cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
        end
        j_nxt     = j_r + {{(ID_W-1){1'b0}}, 1'b1};
        state_nxt = S_ADM_RD;
        if (last_j) begin
          j_nxt = '0;
          unique case (kind_r)
            ADM_FIRST: begin
              prev_nxt     = cur_r;
              prev_neg_nxt = 1'b0;
              found_nxt    = 1'b0;
              state_nxt    = (ring_cnt_nxt != '0) ? S_POP : S_MIN_RD;
            end
            ADM_MIN: begin
              prev_nxt  = cur_r;
              state_nxt = S_POP;
            end
            ADM_DONE: state_nxt = S_TOP;
            ADM_PRE:  state_nxt = S_PUSH;
            default:  state_nxt = S_TOP;
          endcase
        end
      end
      S_MIN_RD: begin
        state_nxt = S_MIN_CK;
      end
      S_MIN_CK: begin
        if (cand) begin
          found_nxt = 1'b1;
          next_nxt  = a_ext;
        end
        j_nxt     = j_r + {{(ID_W-1){1'b0}}, 1'b1};
        state_nxt = S_MIN_RD;
        if (last_j) begin
          j_nxt = '0;
          if (!found_nxt) begin
            state_nxt = S_OUT_RD;
          end else begin
            cur_nxt   = next_nxt;
            kind_nxt  = ADM_MIN;
            state_nxt = S_ADM_RD;
          end
        end
      end
      S_POP: begin
        state_nxt = S_POP2;
      end
      S_POP2: begin
        id_nxt       = ring_rd_r;
        head_nxt     = head_r + {{(ID_W-1){1'b0}}, 1'b1};
        ring_cnt_nxt = ring_cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
        state_nxt    = S_REM;
      end
      S_REM: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (!started_r[id_r]) begin
          start_we            = 1'b1;
          started_nxt[id_r]   = 1'b1;
        end
        prev_nxt     = cur_r;
        prev_neg_nxt = 1'b0;
        j_nxt        = '0;
        state_nxt    = S_ADM_RD;
        if (rem_rd_r <= q_eff) begin
          cur_nxt       = fin_wd;
          fin_we        = 1'b1;
          done_nxt[id_r] = 1'b1;
          fin_cnt_nxt   = fin_cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
          kind_nxt      = ADM_DONE;
        end else begin
          rem_we   = 1'b1;
          cur_nxt  = cur_r + {{(TIME_W-IN_W){1'b0}}, q_eff};
          kind_nxt = ADM_PRE;
        end
      end
      S_PUSH: begin
        ring_we      = 1'b1;
        ring_wd      = id_r;
        tail_nxt     = tail_r + {{(ID_W-1){1'b0}}, 1'b1};
        ring_cnt_nxt = ring_cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
        state_nxt    = S_TOP;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_CK;
      end
      S_OUT_CK: begin
        out_nxt.process_id      = j_r;
        out_nxt.start_time      = start_rd_r;
        out_nxt.finish_time     = fin_rd_r;
        out_nxt.wait_time       = wt;
        out_nxt.turnaround_time = tat;
        out_nxt.last_result     = last_j;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_j) begin
            done_nxt     = '0;
            started_nxt  = '0;
            head_nxt     = '0;
            tail_nxt     = '0;
            ring_cnt_nxt = '0;
            pcount_nxt   = '0;
            fin_cnt_nxt  = '0;
            cur_nxt      = '0;
            prev_neg_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            j_nxt     = j_r + {{(ID_W-1){1'b0}}, 1'b1};
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_cnt_r <= pcount_r)
    else $error("ready queue holds more entries than processes");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT_WAIT)
    else $error("result shown outside output wait");

  a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fin_cnt_r <= pcount_r)
    else $error("more finished processes than loaded");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (done_r == '0 && ring_cnt_r == '0))
    else $error("run state not cleared while loading");
`endif

endmodule
